// ===== rtl/tagged_message_reassembly_macros.svh =====
`ifndef TAGGED_MESSAGE_REASSEMBLY_MACROS_SVH
`define TAGGED_MESSAGE_REASSEMBLY_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define TMR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define TMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tmr_pkg.sv =====
`timescale 1ns / 1ps

package tmr_pkg;

    localparam int DATA_W           = 64;
    localparam int SVC_W            = 8;
    localparam int OUT_ID_W         = 4;
    localparam int IDX_W            = 6;
    localparam int ST_W             = 3;
    localparam int WORDS_PER_PACKET = 7;
    localparam int DESC_BEGIN_BIT   = 0;
    localparam int DESC_END_BIT     = 1;
    localparam int DESC_LEN_LSB     = 5;
    localparam int DESC_LEN_W       = 3;
    localparam int DESC_ID_LSB      = 8;
    localparam int DESC_ID_W        = 56;

    localparam int MAX_IDS_DEF           = 16;
    localparam int MAX_MESSAGE_WORDS_DEF = 56;

    localparam logic [SVC_W-1:0] PRINTF_CODE_RST = 8'd2;

    localparam logic [ST_W-1:0] ST_OK          = 3'd0;
    localparam logic [ST_W-1:0] ST_DEAD_ID     = 3'd1;
    localparam logic [ST_W-1:0] ST_NO_FREE_ID  = 3'd2;
    localparam logic [ST_W-1:0] ST_OVERFLOW    = 3'd3;
    localparam logic [ST_W-1:0] ST_UNSUPPORTED = 3'd4;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_WORD  = 1'b1;

    typedef struct packed {
        logic idle;
        logic lookup;
        logic alloc;
        logic write;
        logic finish;
        logic load_reply;
        logic load_word;
    } t_dp_cmd;

    typedef struct packed {
        logic in_fire;
        logic ok;
        logic has_words;
        logic write_last;
        logic stream;
        logic out_free;
        logic last_word;
    } t_dp_sts;

endpackage

// ===== rtl/tmr_in_if.sv =====
`timescale 1ns / 1ps

interface tmr_in_if;
    logic                         valid;
    logic                         ready;
    logic [tmr_pkg::SVC_W-1:0]    service;
    logic [tmr_pkg::DATA_W-1:0]   descriptor;
    logic [tmr_pkg::DATA_W-1:0]   content_word_1;
    logic [tmr_pkg::DATA_W-1:0]   content_word_2;
    logic [tmr_pkg::DATA_W-1:0]   content_word_3;
    logic [tmr_pkg::DATA_W-1:0]   content_word_4;
    logic [tmr_pkg::DATA_W-1:0]   content_word_5;
    logic [tmr_pkg::DATA_W-1:0]   content_word_6;
    logic [tmr_pkg::DATA_W-1:0]   content_word_7;

    modport source (
        output valid, service, descriptor, content_word_1, content_word_2,
               content_word_3, content_word_4, content_word_5, content_word_6,
               content_word_7,
        input  ready
    );

    modport sink (
        input  valid, service, descriptor, content_word_1, content_word_2,
               content_word_3, content_word_4, content_word_5, content_word_6,
               content_word_7,
        output ready
    );
endinterface

// ===== rtl/tmr_out_if.sv =====
`timescale 1ns / 1ps

interface tmr_out_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [tmr_pkg::DATA_W-1:0]    value;
    logic [tmr_pkg::OUT_ID_W-1:0]  message_id;
    logic [tmr_pkg::IDX_W-1:0]     word_index;
    logic                          last;
    logic [tmr_pkg::ST_W-1:0]      status;

    modport source (
        output valid, kind, value, message_id, word_index, last, status,
        input  ready
    );

    modport sink (
        input  valid, kind, value, message_id, word_index, last, status,
        output ready
    );
endinterface

// ===== rtl/tagged_message_reassembly.sv =====
// Flow: after an input transfer the controller steps through lookup, alloc, one write per
//   content word into the one-write-port message memory (len = word count, 0..7), finish
//   and reply; once the output register is free the reply is loaded, then each assembled
//   word is read via the registered read port and sent. Input ready is high only in idle.
// Reset: synchronous, active low; clears live flags, free-stack count, fresh-id counter and
//   the output valid, and sets the printf service code to 2. Memories are not cleared.
`timescale 1ns / 1ps
`include "tagged_message_reassembly_macros.svh"

module tagged_message_reassembly #(
    parameter int MAX_IDS           = tmr_pkg::MAX_IDS_DEF,
    parameter int MAX_MESSAGE_WORDS = tmr_pkg::MAX_MESSAGE_WORDS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [tmr_pkg::SVC_W-1:0] i_cfg_wdata,
    tmr_in_if.sink                    i_in,
    tmr_out_if.source                 o_out
);

    tmr_pkg::t_dp_cmd cmd;
    tmr_pkg::t_dp_sts sts;

    tmr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tmr_dp #(
        .MAX_IDS           (MAX_IDS),
        .MAX_MESSAGE_WORDS (MAX_MESSAGE_WORDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .o_out       (o_out)
    );

    `TMR_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "input ready right after a transfer")
    `TMR_ASSERT_SAME(a_load_needs_room, i_clk, i_rst_n, cmd.load_reply || cmd.load_word, sts.out_free, "output register overwritten")
    `TMR_ASSERT_SAME(a_write_needs_id, i_clk, i_rst_n, cmd.write, sts.ok, "word written without a valid id")

endmodule

// ===== rtl/tmr_ctrl.sv =====
`timescale 1ns / 1ps

module tmr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tmr_pkg::t_dp_sts i_sts,
    output tmr_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOKUP = 3'd1;
    localparam logic [2:0] S_ALLOC  = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_REPLY  = 3'd5;
    localparam logic [2:0] S_READ   = 3'd6;
    localparam logic [2:0] S_SEND   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_sts.in_fire) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_ALLOC;
            end
            S_ALLOC: begin
                o_cmd.alloc = 1'b1;
                n_state     = (i_sts.ok && i_sts.has_words) ? S_WRITE : S_FINISH;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                if (i_sts.write_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_REPLY;
            end
            S_REPLY: begin
                if (i_sts.out_free) begin
                    o_cmd.load_reply = 1'b1;
                    n_state          = i_sts.stream ? S_READ : S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_sts.out_free) begin
                    o_cmd.load_word = 1'b1;
                    n_state         = i_sts.last_word ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/tmr_dp.sv =====
`timescale 1ns / 1ps

module tmr_dp #(
    parameter int MAX_IDS           = tmr_pkg::MAX_IDS_DEF,
    parameter int MAX_MESSAGE_WORDS = tmr_pkg::MAX_MESSAGE_WORDS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tmr_pkg::SVC_W-1:0]  i_cfg_wdata,
    input  tmr_pkg::t_dp_cmd           i_cmd,
    output tmr_pkg::t_dp_sts           o_sts,
    tmr_in_if.sink                     i_in,
    tmr_out_if.source                  o_out
);

    localparam int ID_W   = $clog2(MAX_IDS);
    localparam int FC_W   = $clog2(MAX_IDS + 1);
    localparam int CNT_W  = $clog2(MAX_MESSAGE_WORDS + 1);
    localparam int DEPTH  = MAX_IDS * MAX_MESSAGE_WORDS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = tmr_pkg::DESC_LEN_W;
    localparam int DW     = tmr_pkg::DATA_W;
    localparam int WPP    = tmr_pkg::WORDS_PER_PACKET;

    // configuration and control state
    logic [tmr_pkg::SVC_W-1:0] r_code;
    logic [MAX_IDS-1:0]        r_live;
    logic [FC_W-1:0]           r_free_cnt;
    logic [FC_W-1:0]           r_fresh;
    logic                      r_out_valid;

    // item context
    logic [tmr_pkg::SVC_W-1:0] r_service;
    logic [DW-1:0]             r_desc;
    logic [DW-1:0]             r_words [WPP];
    logic                      r_ok;
    logic                      r_pop;
    logic [tmr_pkg::ST_W-1:0]  r_status;
    logic [ID_W-1:0]           r_id;
    logic [ADDR_W-1:0]         r_base;
    logic [CNT_W-1:0]          r_cnt;
    logic [LEN_W-1:0]          r_k;
    logic [CNT_W-1:0]          r_nstream;
    logic [CNT_W-1:0]          r_rd_idx;

    // memories
    logic [DW-1:0]             r_msg_mem [DEPTH];
    logic [ID_W-1:0]           r_stk_mem [MAX_IDS];
    logic [CNT_W-1:0]          r_cnt_mem [MAX_IDS];
    logic [DW-1:0]             r_msg_q;
    logic [ID_W-1:0]           r_stk_q;
    logic [CNT_W-1:0]          r_cnt_q;

    // output register
    logic                          r_o_kind;
    logic [DW-1:0]                 r_o_value;
    logic [tmr_pkg::OUT_ID_W-1:0]  r_o_id;
    logic [tmr_pkg::IDX_W-1:0]     r_o_idx;
    logic                          r_o_last;
    logic [tmr_pkg::ST_W-1:0]      r_o_status;

    logic                  in_fire;
    logic                  out_free;
    logic                  desc_begin;
    logic                  desc_end;
    logic [LEN_W-1:0]      desc_len;
    logic [ID_W-1:0]       quoted_idx;
    logic                  quoted_ok;
    logic [ID_W-1:0]       alloc_id;
    logic                  room;
    logic                  last_word;
    logic [CNT_W-1:0]      rd_next;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ID_W-1:0]       stk_rd_idx;
    logic                  msg_we;
    logic                  stk_we;
    logic                  cnt_we;
    logic [CNT_W-1:0]      cnt_wdata;

    assign in_fire    = i_in.valid && i_cmd.idle;
    assign out_free   = !r_out_valid || o_out.ready;
    assign desc_begin = r_desc[tmr_pkg::DESC_BEGIN_BIT];
    assign desc_end   = r_desc[tmr_pkg::DESC_END_BIT];
    assign desc_len   = r_desc[tmr_pkg::DESC_LEN_LSB +: LEN_W];
    assign quoted_idx = r_desc[tmr_pkg::DESC_ID_LSB +: ID_W];
    assign quoted_ok  = (r_desc[DW-1:tmr_pkg::DESC_ID_LSB] < tmr_pkg::DESC_ID_W'(MAX_IDS))
                        && r_live[quoted_idx];
    assign alloc_id   = !desc_begin ? quoted_idx :
                        r_pop       ? r_stk_q    : ID_W'(r_fresh);
    assign room       = r_cnt < CNT_W'(MAX_MESSAGE_WORDS);
    assign rd_next    = r_rd_idx + CNT_W'(1);
    assign last_word  = rd_next == r_nstream;
    assign wr_addr    = r_base + ADDR_W'(r_cnt);
    assign rd_addr    = r_base + ADDR_W'(r_rd_idx);
    assign stk_rd_idx = ID_W'(r_free_cnt - FC_W'(1));
    assign msg_we     = i_cmd.write && room;
    assign stk_we     = i_cmd.finish && r_ok && desc_end && (r_free_cnt < FC_W'(MAX_IDS));
    assign cnt_we     = i_cmd.finish && r_ok;
    assign cnt_wdata  = desc_end ? '0 : r_cnt;

    assign i_in.ready = i_cmd.idle;

    assign o_sts.in_fire    = in_fire;
    assign o_sts.ok         = r_ok;
    assign o_sts.has_words  = desc_len != '0;
    assign o_sts.write_last = r_k == (desc_len - LEN_W'(1));
    assign o_sts.stream     = r_nstream != '0;
    assign o_sts.out_free   = out_free;
    assign o_sts.last_word  = last_word;

    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_o_kind;
    assign o_out.value      = r_o_value;
    assign o_out.message_id = r_o_id;
    assign o_out.word_index = r_o_idx;
    assign o_out.last       = r_o_last;
    assign o_out.status     = r_o_status;

    // memories
    always_ff @(posedge i_clk) begin
        if (msg_we) begin
            r_msg_mem[wr_addr] <= r_words[0];
        end
        r_msg_q <= r_msg_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[ID_W'(r_free_cnt)] <= r_id;
        end
        r_stk_q <= r_stk_mem[stk_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[r_id] <= cnt_wdata;
        end
        r_cnt_q <= r_cnt_mem[quoted_idx];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code      <= tmr_pkg::PRINTF_CODE_RST;
            r_live      <= '0;
            r_free_cnt  <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_code <= i_cfg_wdata;
            end
            if (i_cmd.alloc && r_ok && desc_begin) begin
                r_live[alloc_id] <= 1'b1;
                if (r_pop) begin
                    r_free_cnt <= r_free_cnt - FC_W'(1);
                end else begin
                    r_fresh <= r_fresh + FC_W'(1);
                end
            end
            if (i_cmd.finish && r_ok && desc_end) begin
                r_live[r_id] <= 1'b0;
            end
            if (stk_we) begin
                r_free_cnt <= r_free_cnt + FC_W'(1);
            end
            if (i_cmd.load_reply || i_cmd.load_word) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_service  <= i_in.service;
            r_desc     <= i_in.descriptor;
            r_words[0] <= i_in.content_word_1;
            r_words[1] <= i_in.content_word_2;
            r_words[2] <= i_in.content_word_3;
            r_words[3] <= i_in.content_word_4;
            r_words[4] <= i_in.content_word_5;
            r_words[5] <= i_in.content_word_6;
            r_words[6] <= i_in.content_word_7;
        end

        if (i_cmd.lookup) begin
            r_pop <= r_free_cnt != '0;
            if (desc_begin) begin
                r_ok     <= (r_free_cnt != '0) || (r_fresh < FC_W'(MAX_IDS));
                r_status <= ((r_free_cnt != '0) || (r_fresh < FC_W'(MAX_IDS))) ?
                            tmr_pkg::ST_OK : tmr_pkg::ST_NO_FREE_ID;
            end else begin
                r_ok     <= quoted_ok;
                r_status <= quoted_ok ? tmr_pkg::ST_OK : tmr_pkg::ST_DEAD_ID;
            end
        end

        if (i_cmd.alloc) begin
            r_id   <= alloc_id;
            r_base <= ADDR_W'(alloc_id) * ADDR_W'(MAX_MESSAGE_WORDS);
            r_cnt  <= desc_begin ? '0 : r_cnt_q;
            r_k    <= '0;
        end

        if (i_cmd.write) begin
            for (int i = 0; i < WPP - 1; i++) begin
                r_words[i] <= r_words[i + 1];
            end
            r_k <= r_k + LEN_W'(1);
            if (room) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_status <= tmr_pkg::ST_OVERFLOW;
            end
        end

        if (i_cmd.finish) begin
            r_rd_idx  <= '0;
            r_nstream <= '0;
            if (r_ok && desc_end) begin
                if (r_service == r_code) begin
                    r_nstream <= r_cnt;
                end else if (r_status == tmr_pkg::ST_OK) begin
                    r_status <= tmr_pkg::ST_UNSUPPORTED;
                end
            end
        end

        if (i_cmd.load_word) begin
            r_rd_idx <= rd_next;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_reply) begin
            r_o_kind   <= tmr_pkg::KIND_REPLY;
            r_o_idx    <= '0;
            r_o_last   <= r_nstream == '0;
            r_o_status <= r_status;
            if (desc_begin && r_ok) begin
                r_o_value <= {tmr_pkg::DESC_ID_W'(r_id),
                              r_desc[tmr_pkg::DESC_ID_LSB-1:1], 1'b0};
                r_o_id    <= tmr_pkg::OUT_ID_W'(r_id);
            end else begin
                r_o_value <= r_desc;
                r_o_id    <= desc_begin ? '0 :
                             r_desc[tmr_pkg::DESC_ID_LSB +: tmr_pkg::OUT_ID_W];
            end
        end else if (i_cmd.load_word) begin
            r_o_kind   <= tmr_pkg::KIND_WORD;
            r_o_value  <= r_msg_q;
            r_o_id     <= tmr_pkg::OUT_ID_W'(r_id);
            r_o_idx    <= tmr_pkg::IDX_W'(r_rd_idx);
            r_o_last   <= last_word;
            r_o_status <= r_status;
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tmr_pkg::*;

    localparam int MAX_IDS          = MAX_IDS_DEF;
    localparam int MAX_MSG_WORDS    = MAX_MESSAGE_WORDS_DEF;
    localparam int DRAIN_CYCLES     = 30;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 3000;

    typedef struct packed {
        logic [SVC_W-1:0]                         service;
        logic [DATA_W-1:0]                        descriptor;
        logic [WORDS_PER_PACKET-1:0][DATA_W-1:0]  words;
    } packet_t;

    typedef struct packed {
        logic                 kind;
        logic [DATA_W-1:0]    value;
        logic [OUT_ID_W-1:0]  message_id;
        logic [IDX_W-1:0]     word_index;
        logic                 last;
        logic [ST_W-1:0]      status;
    } result_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [SVC_W-1:0] i_cfg_wdata;

    tmr_in_if  in_if ();
    tmr_out_if out_if ();

    tagged_message_reassembly i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // reassembly state as the block should hold it
    bit               live_ids [MAX_IDS]      = '{default: 1'b0};
    int unsigned      msg_len [MAX_IDS]       = '{default: 0};
    logic [DATA_W-1:0] msg_words [MAX_IDS*MAX_MSG_WORDS];
    int unsigned      free_ids [MAX_IDS]      = '{default: 0};
    int unsigned      free_top                = 0;
    int unsigned      fresh_id                = 0;
    logic [SVC_W-1:0] printf_code             = PRINTF_CODE_RST;
    int unsigned      last_alloc_id           = 0;

    result_t     pending_results [$];
    int unsigned errors       = 0;
    int unsigned quiet_cycles = 0;
    bit          source_gaps  = 1'b1;
    bit          sink_stalls  = 1'b1;
    bit          hold_request = 1'b0;
    bit          sink_holding = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reassemble_packet(input packet_t pkt);
        logic              begin_bit;
        logic              end_bit;
        int unsigned       len;
        int unsigned       id;
        int unsigned       cnt;
        int unsigned       nwords;
        logic [DESC_ID_W-1:0] quoted;
        logic [DATA_W-1:0] reply;
        logic [OUT_ID_W-1:0] shown;
        logic [ST_W-1:0]   st;
        bit                ok;
        result_t           r;
        begin_bit = pkt.descriptor[DESC_BEGIN_BIT];
        end_bit   = pkt.descriptor[DESC_END_BIT];
        len       = int'(pkt.descriptor[DESC_LEN_LSB +: DESC_LEN_W]);
        quoted    = pkt.descriptor[DATA_W-1:DESC_ID_LSB];
        reply     = pkt.descriptor;
        shown     = '0;
        st        = ST_OK;
        id        = 0;
        ok        = 1'b0;
        nwords    = 0;
        if (begin_bit) begin
            if (free_top > 0) begin
                free_top--;
                id = free_ids[free_top] % MAX_IDS;
                ok = 1'b1;
            end else if (fresh_id < MAX_IDS) begin
                id = fresh_id;
                fresh_id++;
                ok = 1'b1;
            end else begin
                st = ST_NO_FREE_ID;
            end
            if (ok) begin
                live_ids[id] = 1'b1;
                msg_len[id] = 0;
                reply = '0;
                reply[DESC_LEN_LSB+DESC_LEN_W-1:DESC_END_BIT] =
                    pkt.descriptor[DESC_LEN_LSB+DESC_LEN_W-1:DESC_END_BIT];
                reply[DATA_W-1:DESC_ID_LSB] = DESC_ID_W'(id);
                shown = OUT_ID_W'(id);
                last_alloc_id = id;
            end
        end else begin
            shown = quoted[OUT_ID_W-1:0];
            if (quoted < MAX_IDS && live_ids[quoted[OUT_ID_W-1:0]]) begin
                id = int'(quoted[OUT_ID_W-1:0]);
                ok = 1'b1;
            end else begin
                st = ST_DEAD_ID;
            end
        end
        if (ok) begin
            for (int k = 0; k < len; k++) begin
                if (msg_len[id] < MAX_MSG_WORDS) begin
                    msg_words[id*MAX_MSG_WORDS + msg_len[id]] = pkt.words[k];
                    msg_len[id]++;
                end else begin
                    st = ST_OVERFLOW;
                end
            end
            if (end_bit) begin
                cnt = msg_len[id];
                live_ids[id] = 1'b0;
                msg_len[id] = 0;
                if (free_top < MAX_IDS) begin
                    free_ids[free_top] = id;
                    free_top++;
                end
                if (pkt.service == printf_code) begin
                    nwords = cnt;
                end else if (st == ST_OK) begin
                    st = ST_UNSUPPORTED;
                end
            end
        end
        r.kind       = KIND_REPLY;
        r.value      = reply;
        r.message_id = shown;
        r.word_index = '0;
        r.last       = (nwords == 0);
        r.status     = st;
        pending_results.push_back(r);
        for (int k = 0; k < nwords; k++) begin
            r.kind       = KIND_WORD;
            r.value      = msg_words[id*MAX_MSG_WORDS + k];
            r.message_id = OUT_ID_W'(id);
            r.word_index = IDX_W'(k);
            r.last       = (k + 1 == nwords);
            pending_results.push_back(r);
        end
    endfunction

    function automatic packet_t make_packet(input logic [SVC_W-1:0] svc, input bit b,
                                            input bit e, input int unsigned len,
                                            input logic [DESC_ID_W-1:0] id);
        packet_t pkt;
        pkt.service = svc;
        pkt.descriptor = '0;
        pkt.descriptor[DESC_BEGIN_BIT] = b;
        pkt.descriptor[DESC_END_BIT] = e;
        pkt.descriptor[DESC_LEN_LSB-1:DESC_END_BIT+1] =
            (DESC_LEN_LSB-DESC_END_BIT-1)'($urandom);
        pkt.descriptor[DESC_LEN_LSB +: DESC_LEN_W] = DESC_LEN_W'(len);
        pkt.descriptor[DATA_W-1:DESC_ID_LSB] = id;
        for (int k = 0; k < WORDS_PER_PACKET; k++)
            pkt.words[k] = {$urandom, $urandom};
        return pkt;
    endfunction

    // pick a random id that is live (or not live) right now
    function automatic bit pick_id(input bit want_live, output int unsigned id);
        int unsigned found [$];
        for (int k = 0; k < MAX_IDS; k++)
            if (live_ids[k] == want_live)
                found.push_back(k);
        id = 0;
        if (found.size() == 0)
            return 1'b0;
        id = found[$urandom_range(0, found.size() - 1)];
        return 1'b1;
    endfunction

    function automatic packet_t random_packet();
        packet_t          pkt;
        int unsigned      pick;
        int unsigned      id;
        bit               have_live;
        bit               have_dead;
        logic [SVC_W-1:0] svc;
        pick = $urandom_range(0, 99);
        svc = ($urandom_range(0, 4) == 0) ? SVC_W'($urandom) : printf_code;
        have_live = pick_id(1'b1, id);
        if (pick < 10) begin
            pkt = make_packet(SVC_W'($urandom), 1'b0, 1'b0, 0, '0);
            pkt.descriptor = {$urandom, $urandom};
        end else if (pick < 20) begin
            have_dead = pick_id(1'b0, id);
            if (have_dead && $urandom_range(0, 1) == 0)
                pkt = make_packet(svc, 1'b0, $urandom_range(0, 1) == 0,
                                  $urandom_range(0, 7), DESC_ID_W'(id));
            else
                pkt = make_packet(svc, 1'b0, $urandom_range(0, 1) == 0,
                                  $urandom_range(0, 7), DESC_ID_W'({$urandom, $urandom}));
        end else if (pick < 42 || !have_live) begin
            pkt = make_packet(svc, 1'b1, $urandom_range(0, 6) == 0,
                              $urandom_range(0, 7), DESC_ID_W'({$urandom, $urandom}));
        end else begin
            pkt = make_packet(svc, 1'b0, $urandom_range(0, 5) == 0,
                              $urandom_range(0, 7), DESC_ID_W'(id));
        end
        return pkt;
    endfunction

    task automatic send_packet(input packet_t pkt);
        int gap;
        if (source_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.service        <= pkt.service;
        in_if.descriptor     <= pkt.descriptor;
        in_if.content_word_1 <= pkt.words[0];
        in_if.content_word_2 <= pkt.words[1];
        in_if.content_word_3 <= pkt.words[2];
        in_if.content_word_4 <= pkt.words[3];
        in_if.content_word_5 <= pkt.words[4];
        in_if.content_word_6 <= pkt.words[5];
        in_if.content_word_7 <= pkt.words[6];
        do @(posedge i_clk); while (!in_if.ready);
        reassemble_packet(pkt);
    endtask

    // drop valid and wait out every outstanding result
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_service_code(input logic [SVC_W-1:0] code);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        printf_code = code;
    endtask

    task automatic test_directed_cases();
        packet_t     pkt;
        int unsigned id;
        send_packet(make_packet(printf_code, 1'b1, 1'b1, 0, '0));
        pkt = make_packet(printf_code, 1'b1, 1'b0, 7, '0);
        pkt.words = '0;
        send_packet(pkt);
        id = last_alloc_id;
        pkt = make_packet(printf_code, 1'b0, 1'b0, 7, DESC_ID_W'(id));
        pkt.words = '1;
        send_packet(pkt);
        send_packet(make_packet(printf_code, 1'b0, 1'b0, 1, DESC_ID_W'(id)));
        send_packet(make_packet(printf_code, 1'b0, 1'b1, 3, DESC_ID_W'(id)));
        send_packet(make_packet(printf_code, 1'b0, 1'b0, 2, DESC_ID_W'(id)));
        send_packet(make_packet(printf_code, 1'b0, 1'b1, 0, '1));
        send_packet(make_packet(printf_code, 1'b0, 1'b0, 4, DESC_ID_W'(MAX_IDS)));
        send_packet(make_packet(printf_code, 1'b1, 1'b0, 2, '0));
        id = last_alloc_id;
        send_packet(make_packet(8'hFF, 1'b0, 1'b1, 2, DESC_ID_W'(id)));
        send_packet(make_packet(printf_code, 1'b1, 1'b0, 0, '1));
        id = last_alloc_id;
        send_packet(make_packet(8'h00, 1'b0, 1'b1, 0, DESC_ID_W'(id)));
        send_packet(make_packet(printf_code, 1'b1, 1'b1, 7, '0));
        pkt = make_packet(printf_code, 1'b1, 1'b1, 7, '1);
        pkt.descriptor = '1;
        send_packet(pkt);
        pkt = make_packet(8'h00, 1'b0, 1'b0, 0, '0);
        pkt.descriptor = '0;
        pkt.words = '0;
        send_packet(pkt);
        send_packet(make_packet(8'hFF, 1'b1, 1'b1, 7, '0));
    endtask

    task automatic test_overflow();
        int unsigned id;
        send_packet(make_packet(printf_code, 1'b1, 1'b0, 7, '0));
        id = last_alloc_id;
        repeat (8) send_packet(make_packet(printf_code, 1'b0, 1'b0, 7, DESC_ID_W'(id)));
        send_packet(make_packet(printf_code, 1'b0, 1'b1, 3, DESC_ID_W'(id)));
        send_packet(make_packet(printf_code, 1'b1, 1'b0, 7, '0));
        id = last_alloc_id;
        repeat (8) send_packet(make_packet(printf_code, 1'b0, 1'b0, 7, DESC_ID_W'(id)));
        send_packet(make_packet(printf_code ^ 8'h55, 1'b0, 1'b1, 1, DESC_ID_W'(id)));
    endtask

    task automatic test_id_exhaustion();
        int unsigned id;
        while (pick_id(1'b1, id))
            send_packet(make_packet(SVC_W'($urandom), 1'b0, 1'b1, 0, DESC_ID_W'(id)));
        repeat (MAX_IDS + 2)
            send_packet(make_packet(printf_code, 1'b1, 1'b0, $urandom_range(0, 7), '0));
        while (pick_id(1'b1, id))
            send_packet(make_packet(printf_code, 1'b0, 1'b1, $urandom_range(0, 7),
                                    DESC_ID_W'(id)));
        repeat (4)
            send_packet(make_packet(printf_code, 1'b1, 1'b0, $urandom_range(0, 7), '0));
        while (pick_id(1'b1, id))
            send_packet(make_packet(printf_code, 1'b0, 1'b1, $urandom_range(0, 7),
                                    DESC_ID_W'(id)));
    endtask

    task automatic run_random(input int unsigned count, input bit allow_idle);
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                source_gaps = allow_idle && $urandom_range(0, 2) != 0;
                sink_stalls = allow_idle && $urandom_range(0, 2) != 0;
            end
            send_packet(random_packet());
        end
    endtask

    task automatic test_service_codes();
        run_random(100, 1'b1);
        write_service_code(8'h00);
        run_random(80, 1'b1);
        write_service_code(8'hFF);
        run_random(80, 1'b1);
        write_service_code(SVC_W'($urandom_range(1, 254)));
        run_random(60, 1'b1);
        write_service_code(PRINTF_CODE_RST);
    endtask

    // stall the output long enough that the block backs up into its input
    task automatic test_output_backpressure();
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        hold_request = 1'b1;
        while (!sink_holding) @(posedge i_clk);
        repeat (20) send_packet(make_packet(printf_code, 1'b1, 1'b1, 7, '0));
    endtask

    task automatic test_unpaced_tail();
        run_random(60, 1'b0);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        result_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual kind %0d value %h",
                         $time, out_if.kind, out_if.value);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", DATA_W'(want.kind), DATA_W'(out_if.kind));
                check_field("value", want.value, out_if.value);
                check_field("message_id", DATA_W'(want.message_id), DATA_W'(out_if.message_id));
                check_field("word_index", DATA_W'(want.word_index), DATA_W'(out_if.word_index));
                check_field("last", DATA_W'(want.last), DATA_W'(out_if.last));
                check_field("status", DATA_W'(want.status), DATA_W'(out_if.status));
            end
        end
    end

    initial begin : sink_pacing
        int burst;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                sink_holding = 1'b1;
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                out_if.ready <= 1'b1;
                sink_holding = 1'b0;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 15);
                out_if.ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : run
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = '0;
        in_if.valid          = 1'b0;
        in_if.service        = '0;
        in_if.descriptor     = '0;
        in_if.content_word_1 = '0;
        in_if.content_word_2 = '0;
        in_if.content_word_3 = '0;
        in_if.content_word_4 = '0;
        in_if.content_word_5 = '0;
        in_if.content_word_6 = '0;
        in_if.content_word_7 = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_overflow();
        test_id_exhaustion();
        test_service_codes();
        test_output_backpressure();
        test_unpaced_tail();
        drain_results();
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
